@@ hw/rtl/euler_path_finder_top_defines.svh @@
// Assertion macros for the Euler path finder.
// Depends on i_clk and i_rst_n in the module that includes this file.
`ifndef EULER_PATH_FINDER_TOP_DEFINES_SVH
`define EULER_PATH_FINDER_TOP_DEFINES_SVH
// Same-cycle implication, held off during reset.
`define EPF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("epf: same-cycle check failed");
// Next-cycle implication, held off during reset.
`define EPF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("epf: next-cycle check failed");
`endif

@@ hw/rtl/epf_pkg.sv @@
// Constants, codes and address helper for the Euler path finder.
// No dependencies.
package epf_pkg;
    localparam int VW          = 4;
    localparam int MAX_VERTICES = 16;
    localparam int MAX_DEGREE  = 6;
    localparam int SLOTS       = MAX_DEGREE + 1;
    localparam int WALK_DEPTH  = (MAX_VERTICES * MAX_DEGREE) / 2 + 2;
    localparam int ADJ_DEPTH   = MAX_VERTICES * SLOTS;
    localparam int ADJ_AW      = $clog2(ADJ_DEPTH);
    localparam int STK_AW      = $clog2(WALK_DEPTH);
    localparam int CW          = $clog2(WALK_DEPTH + 1);
    localparam int DEG_W       = $clog2(MAX_DEGREE + 1);
    localparam int SW          = $clog2(SLOTS);
    localparam int NW          = $clog2(MAX_VERTICES + 1);

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_RUN = 2'd1;
    localparam logic [1:0] ACT_CLR = 2'd2;

    localparam logic [2:0] ST_CYCLE = 3'd0;
    localparam logic [2:0] ST_PATH  = 3'd1;
    localparam logic [2:0] ST_ODD   = 3'd2;
    localparam logic [2:0] ST_DISC  = 3'd3;
    localparam logic [2:0] ST_OVF   = 3'd4;

    function automatic logic [ADJ_AW-1:0] adj_addr(input logic [VW-1:0] v,
                                                   input logic [SW-1:0] s);
        adj_addr = ADJ_AW'(v) * ADJ_AW'(SLOTS) + ADJ_AW'(s);
    endfunction
endpackage

@@ hw/rtl/epf_ram.sv @@
// Generic simple dual-port RAM with registered read.
// No dependencies.
module epf_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

@@ hw/rtl/euler_path_finder_top.sv @@
// Euler path finder: load and clear items are taken while idle and do not stall the input.
// A run walks the graph: per edge it reads the neighbour from the adjacency RAM (skipped
// for the temporary edge), range-checks it and scans the partner's slots one by one; each
// pop reads the new stack top. Each result passes the walk buffer RAM and output register.
// Synchronous active-low reset empties the graph, clears overflow, sets 16 vertices.
// Depends on epf_pkg, epf_ram and euler_path_finder_top_defines.svh.
`include "euler_path_finder_top_defines.svh"
module euler_path_finder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [4:0] i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_action,
    input  logic [3:0] i_vertex,
    input  logic [3:0] i_neighbor,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_path_vertex,
    output logic [2:0] o_status,
    output logic       o_last
);
    localparam int VW = epf_pkg::VW;
    localparam int MV = epf_pkg::MAX_VERTICES;
    localparam int SL = epf_pkg::SLOTS;
    localparam int SW = epf_pkg::SW;
    localparam int CW = epf_pkg::CW;
    localparam int NW = epf_pkg::NW;
    localparam int AAW = epf_pkg::ADJ_AW;
    localparam int SAW = epf_pkg::STK_AW;
    localparam int DW = epf_pkg::DEG_W;

    // Controller states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TOP  = 4'd1;  // inspect stack top
    localparam logic [3:0] S_RDN  = 4'd2;  // neighbour read returns
    localparam logic [3:0] S_NXT  = 4'd3;  // range check on neighbour
    localparam logic [3:0] S_SRD  = 4'd4;  // read partner slot
    localparam logic [3:0] S_SCK  = 4'd5;  // check partner slot
    localparam logic [3:0] S_POP  = 4'd6;  // new stack top returns
    localparam logic [3:0] S_FIN  = 4'd7;  // leftover and cut checks
    localparam logic [3:0] S_ERD  = 4'd8;  // read walk buffer
    localparam logic [3:0] S_EWT  = 4'd9;  // load output register
    localparam logic [3:0] S_OUT  = 4'd10; // wait for the item to be taken

    logic [3:0]                r_state, n_state;
    logic [NW-1:0]             r_vcount, n_vcount;
    logic                      r_ovf, n_ovf;
    logic [DW-1:0]             r_deg [MV];
    logic [DW-1:0]             n_deg [MV];
    logic [MV-1:0][SL-1:0]     r_live, n_live;
    logic                      r_path, n_path;
    logic [VW-1:0]             r_v1, n_v1, r_v2, n_v2;
    logic [SW-1:0]             r_s1, n_s1, r_s2, n_s2;
    logic [VW-1:0]             r_cur, n_cur, r_nxt, n_nxt;
    logic                      r_temp, n_temp;
    logic [SW-1:0]             r_t, n_t;
    logic [CW-1:0]             r_sp, n_sp, r_len, n_len, r_cut, n_cut, r_tdepth, n_tdepth;
    logic                      r_pending, n_pending;
    logic [SAW-1:0]            r_idx, n_idx;
    logic                      r_phase, n_phase;
    logic                      r_o_valid, n_o_valid;
    logic [VW-1:0]             r_o_vertex, n_o_vertex;
    logic [2:0]                r_o_status, n_o_status;
    logic                      r_o_last, n_o_last;

    // RAM ports
    logic            adj_we;
    logic [AAW-1:0]  adj_waddr, adj_raddr;
    logic [VW-1:0]   adj_wdata, adj_rdata;
    logic            stk_we;
    logic [SAW-1:0]  stk_waddr, stk_raddr;
    logic [VW-1:0]   stk_wdata, stk_rdata;
    logic            buf_we;
    logic [SAW-1:0]  buf_waddr, buf_raddr;
    logic [VW-1:0]   buf_wdata, buf_rdata;

    epf_ram #(.WIDTH(VW), .DEPTH(epf_pkg::ADJ_DEPTH)) u_adj (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_waddr), .i_wdata(adj_wdata),
        .i_raddr(adj_raddr), .o_rdata(adj_rdata)
    );
    epf_ram #(.WIDTH(VW), .DEPTH(epf_pkg::WALK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );
    epf_ram #(.WIDTH(VW), .DEPTH(epf_pkg::WALK_DEPTH)) u_buf (
        .i_clk(i_clk), .i_we(buf_we), .i_waddr(buf_waddr), .i_wdata(buf_wdata),
        .i_raddr(buf_raddr), .o_rdata(buf_rdata)
    );

    logic            in_acc;
    logic [NW-1:0]   n_act;
    logic [MV-1:0]   odd_bits, odd_rest;
    logic [NW-1:0]   odd_cnt;
    logic [VW-1:0]   odd_v1, odd_v2;
    logic            run_path;
    logic [MV-1:0][SL-1:0] live_init;
    logic [SW-1:0]   top_s;
    logic            top_mark, chk_mark;
    logic [VW-1:0]   chk_nb;
    logic            e_last;
    logic            do_err;
    logic [2:0]      err_code;

    assign in_acc  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_o_valid;
    assign o_path_vertex = r_o_vertex;
    assign o_status = r_o_status;
    assign o_last = r_o_last;

    // Active vertex count: clamp to 1..MAX_VERTICES
    always_comb begin
        if (r_vcount > NW'(MV)) begin
            n_act = NW'(MV);
        end else if (r_vcount == '0) begin
            n_act = NW'(1);
        end else begin
            n_act = r_vcount;
        end
    end

    // Odd-degree vertices and the start-of-run live map
    always_comb begin
        odd_v1 = '0;
        odd_v2 = '0;
        for (int v = 0; v < MV; v++) begin
            odd_bits[v] = r_deg[v][0] && (NW'(v) < n_act);
        end
        odd_cnt = NW'($countones(odd_bits));
        for (int v = MV - 1; v >= 0; v--) begin
            if (odd_bits[v]) odd_v1 = VW'(v);
        end
        odd_rest = odd_bits;
        odd_rest[odd_v1] = 1'b0;
        for (int v = MV - 1; v >= 0; v--) begin
            if (odd_rest[v]) odd_v2 = VW'(v);
        end
        run_path = (odd_cnt == NW'(2));
        for (int v = 0; v < MV; v++) begin
            for (int s = 0; s < SL; s++) begin
                live_init[v][s] = ((NW'(v) < n_act) && (DW'(s) < r_deg[v])) ||
                    (run_path && ((VW'(v) == odd_v1 && DW'(s) == r_deg[odd_v1]) ||
                                  (VW'(v) == odd_v2 && DW'(s) == r_deg[odd_v2])));
            end
        end
    end

    // Highest live slot of the stack top, temporary-edge marks and the last-result flag
    always_comb begin
        top_s = '0;
        for (int s = 0; s < SL; s++) begin
            if (r_live[r_cur][s]) top_s = SW'(s);
        end
        top_mark = r_path && ((r_cur == r_v1 && top_s == r_s1) ||
                              (r_cur == r_v2 && top_s == r_s2));
        chk_mark = r_path && ((r_nxt == r_v1 && r_t == r_s1) ||
                              (r_nxt == r_v2 && r_t == r_s2));
        chk_nb = chk_mark ? ((r_nxt == r_v1) ? r_v2 : r_v1) : adj_rdata;
        if (r_path && !r_phase) begin
            e_last = (CW'(r_idx) == r_len - CW'(1)) && (r_cut == '0);
        end else if (r_path) begin
            e_last = (CW'(r_idx) == r_cut);
        end else begin
            e_last = (CW'(r_idx) == r_len - CW'(1));
        end
    end

    always_comb begin
        n_state = r_state;   n_vcount = r_vcount; n_ovf = r_ovf;
        n_deg = r_deg;       n_live = r_live;     n_path = r_path;
        n_v1 = r_v1;         n_v2 = r_v2;         n_s1 = r_s1;     n_s2 = r_s2;
        n_cur = r_cur;       n_nxt = r_nxt;       n_temp = r_temp; n_t = r_t;
        n_sp = r_sp;         n_len = r_len;       n_cut = r_cut;   n_tdepth = r_tdepth;
        n_pending = r_pending; n_idx = r_idx;     n_phase = r_phase;
        n_o_valid = r_o_valid; n_o_vertex = r_o_vertex;
        n_o_status = r_o_status; n_o_last = r_o_last;
        adj_we = 1'b0;
        adj_waddr = epf_pkg::adj_addr(i_vertex, SW'(r_deg[i_vertex]));
        adj_wdata = i_neighbor;
        adj_raddr = epf_pkg::adj_addr(r_nxt, r_t);
        stk_we = 1'b0;
        stk_waddr = r_sp[SAW-1:0];
        stk_wdata = r_nxt;
        stk_raddr = SAW'(r_sp - CW'(2));
        buf_we = 1'b0;
        buf_waddr = r_len[SAW-1:0];
        buf_wdata = r_cur;
        buf_raddr = r_idx;
        do_err = 1'b0;
        err_code = epf_pkg::ST_DISC;

        if (i_cfg_wr_en) n_vcount = i_cfg_wr_data;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_action)
                        epf_pkg::ACT_ADD: begin
                            if (NW'(i_vertex) < n_act && NW'(i_neighbor) < n_act) begin
                                if (r_deg[i_vertex] >= DW'(epf_pkg::MAX_DEGREE)) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    adj_we = 1'b1;
                                    n_deg[i_vertex] = r_deg[i_vertex] + DW'(1);
                                end
                            end
                        end
                        epf_pkg::ACT_CLR: begin
                            for (int v = 0; v < MV; v++) n_deg[v] = '0;
                            n_ovf = 1'b0;
                        end
                        epf_pkg::ACT_RUN: begin
                            if (r_ovf) begin
                                do_err = 1'b1;
                                err_code = epf_pkg::ST_OVF;
                            end else if (odd_cnt != '0 && !run_path) begin
                                do_err = 1'b1;
                                err_code = epf_pkg::ST_ODD;
                            end else begin
                                n_path = run_path;
                                n_v1 = odd_v1;
                                n_v2 = odd_v2;
                                n_s1 = SW'(r_deg[odd_v1]);
                                n_s2 = SW'(r_deg[odd_v2]);
                                n_live = live_init;
                                stk_we = 1'b1;
                                stk_waddr = '0;
                                stk_wdata = run_path ? odd_v1 : '0;
                                n_cur = run_path ? odd_v1 : '0;
                                n_sp = CW'(1);
                                n_len = '0;
                                n_cut = '0;
                                n_tdepth = '0;
                                n_pending = 1'b0;
                                n_state = S_TOP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_TOP: begin
                if (|r_live[r_cur]) begin
                    // Take the highest live edge out of the current vertex
                    n_live[r_cur][top_s] = 1'b0;
                    n_temp = top_mark;
                    if (top_mark) begin
                        n_nxt = (r_cur == r_v1) ? r_v2 : r_v1;
                        n_state = S_NXT;
                    end else begin
                        adj_raddr = epf_pkg::adj_addr(r_cur, top_s);
                        n_state = S_RDN;
                    end
                end else begin
                    // Dead end: pop the vertex into the walk buffer
                    if (r_pending && r_sp == r_tdepth) begin
                        n_cut = r_len;
                        n_pending = 1'b0;
                    end
                    if (r_len >= CW'(epf_pkg::WALK_DEPTH)) begin
                        do_err = 1'b1;
                    end else begin
                        buf_we = 1'b1;
                        n_len = r_len + CW'(1);
                        n_sp = r_sp - CW'(1);
                        n_state = (r_sp == CW'(1)) ? S_FIN : S_POP;
                    end
                end
            end
            S_RDN: begin
                n_nxt = adj_rdata;
                n_state = S_NXT;
            end
            S_NXT: begin
                if (NW'(r_nxt) >= n_act) begin
                    do_err = 1'b1;
                end else begin
                    n_t = '0;
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                n_state = S_SCK;
            end
            S_SCK: begin
                if (r_live[r_nxt][r_t] && chk_nb == r_cur && chk_mark == r_temp) begin
                    n_live[r_nxt][r_t] = 1'b0;
                    if (r_sp >= CW'(epf_pkg::WALK_DEPTH)) begin
                        do_err = 1'b1;
                    end else begin
                        stk_we = 1'b1;
                        n_sp = r_sp + CW'(1);
                        n_cur = r_nxt;
                        if (r_temp) begin
                            n_pending = 1'b1;
                            n_tdepth = r_sp + CW'(1);
                        end
                        n_state = S_TOP;
                    end
                end else if (r_t == SW'(SL - 1)) begin
                    do_err = 1'b1;
                end else begin
                    n_t = r_t + SW'(1);
                    n_state = S_SRD;
                end
            end
            S_POP: begin
                n_cur = stk_rdata;
                n_state = S_TOP;
            end
            S_FIN: begin
                n_phase = 1'b0;
                if (|r_live) begin
                    do_err = 1'b1;
                end else if (r_path) begin
                    if (r_pending || r_cut + CW'(1) >= r_len) begin
                        do_err = 1'b1;
                    end else begin
                        n_idx = SAW'(r_cut + CW'(1));
                        n_state = S_ERD;
                    end
                end else begin
                    n_idx = '0;
                    n_state = S_ERD;
                end
            end
            S_ERD: begin
                n_state = S_EWT;
            end
            S_EWT: begin
                n_o_vertex = buf_rdata;
                n_o_status = r_path ? epf_pkg::ST_PATH : epf_pkg::ST_CYCLE;
                n_o_last = e_last;
                n_o_valid = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_o_valid = 1'b0;
                    if (r_o_last) begin
                        n_state = S_IDLE;
                    end else begin
                        // Advance; a path wraps to index one after the tail
                        if (r_path && !r_phase && CW'(r_idx) == r_len - CW'(1)) begin
                            n_phase = 1'b1;
                            n_idx = SAW'(1);
                        end else begin
                            n_idx = r_idx + SAW'(1);
                        end
                        n_state = S_ERD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (do_err) begin
            n_o_vertex = '0;
            n_o_status = err_code;
            n_o_last = 1'b1;
            n_o_valid = 1'b1;
            n_state = S_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vcount <= NW'(MV);
            r_ovf <= 1'b0;
            for (int v = 0; v < MV; v++) r_deg[v] <= '0;
            r_o_valid <= 1'b0;
            r_pending <= 1'b0;
            r_sp <= '0;
            r_len <= '0;
        end else begin
            r_state <= n_state;
            r_vcount <= n_vcount;
            r_ovf <= n_ovf;
            r_deg <= n_deg;
            r_o_valid <= n_o_valid;
            r_pending <= n_pending;
            r_sp <= n_sp;
            r_len <= n_len;
        end
        r_live <= n_live;   r_path <= n_path;
        r_v1 <= n_v1;       r_v2 <= n_v2;     r_s1 <= n_s1;   r_s2 <= n_s2;
        r_cur <= n_cur;     r_nxt <= n_nxt;   r_temp <= n_temp; r_t <= n_t;
        r_cut <= n_cut;     r_tdepth <= n_tdepth;
        r_idx <= n_idx;     r_phase <= n_phase;
        r_o_vertex <= n_o_vertex; r_o_status <= n_o_status; r_o_last <= n_o_last;
    end

    `EPF_ASSERT_IMP(a_idle_no_result, !o_stall, !r_o_valid)
    `EPF_ASSERT_IMP(a_sp_bound, 1'b1, r_sp <= CW'(epf_pkg::WALK_DEPTH))
    `EPF_ASSERT_IMP(a_len_bound, 1'b1, r_len <= CW'(epf_pkg::WALK_DEPTH))
    `EPF_ASSERT_NXT(a_last_to_idle, r_o_valid && !i_stall && r_o_last, r_state == S_IDLE)
endmodule
